// ===== design/dct_pkg.sv =====
// ---------------------------------------------------------------------------
// dct_pkg
// Shared constants, types and the cosine ROM of the 8x8 DCT block.
// ---------------------------------------------------------------------------
package dct_pkg;

    localparam int COEF_FRAC_BITS_DEF = 30;
    localparam int SAMPLE_BITS_DEF    = 16;
    localparam int DATA_W             = 16;
    localparam int ROM_FRAC_BITS      = 40;
    localparam int BLK_ITEMS          = 64;
    localparam int IDX_W              = 6;
    localparam int COS_ENTRIES        = 9;

    // 0.5*cos(k*pi/16), k = 0..8
    localparam logic [ROM_FRAC_BITS-1:0] COS_ROM [COS_ENTRIES] = '{
        40'd549755813888, 40'd539192410077, 40'd507908144330, 40'd457105253435,
        40'd388736063997, 40'd305427965626, 40'd210382441821, 40'd107252038762,
        40'd0
    };
    // sqrt(1/8)
    localparam logic [ROM_FRAC_BITS-1:0] DC_ROM = 40'd388736063997;

    typedef struct packed {
        logic inverse;
    } job_t;

    typedef struct packed {
        logic input_busy;
    } back_status_t;

    function automatic logic [ROM_FRAC_BITS:0] rom_round(
        input logic [ROM_FRAC_BITS-1:0] t,
        input int                       cfb
    );
        int                     sh;
        logic [ROM_FRAC_BITS:0] w;
        begin
            sh = ROM_FRAC_BITS - cfb;
            w  = {1'b0, t};
            if (sh > 0)
            begin
                w = (w + ((ROM_FRAC_BITS+1)'(1) << (sh - 1))) >> sh;
            end
            return w;
        end
    endfunction

endpackage

// ===== design/dct_ram.sv =====
// ---------------------------------------------------------------------------
// dct_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module dct_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/dct_front.sv =====
// ---------------------------------------------------------------------------
// dct_front
// Sample loader: counts items into the input store and queues a job per block.
// ---------------------------------------------------------------------------
module dct_front #(
    parameter int SAMPLE_BITS = dct_pkg::SAMPLE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [dct_pkg::DATA_W-1:0]  sample_value,
    input  logic                        cfg_write_en,
    input  logic                        cfg_write_data,
    input  logic                        q_empty,
    input  dct_pkg::back_status_t       status,
    output logic                        ram_we,
    output logic [dct_pkg::IDX_W-1:0]   ram_waddr,
    output logic [SAMPLE_BITS-1:0]      ram_wdata,
    output logic                        push,
    output dct_pkg::job_t               push_job
);
    import dct_pkg::*;

    logic [IDX_W-1:0] load_cnt_reg;
    logic             mode_reg;
    logic             accept;

    assign in_ready  = q_empty && !status.input_busy;
    assign accept    = in_valid && in_ready;
    assign ram_we    = accept;
    assign ram_waddr = load_cnt_reg;
    assign ram_wdata = sample_value[SAMPLE_BITS-1:0];
    assign push      = accept && (load_cnt_reg == IDX_W'(BLK_ITEMS - 1));
    assign push_job.inverse = mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_cnt_reg <= '0;
            mode_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                mode_reg <= cfg_write_data;
            end
            if (accept)
            begin
                load_cnt_reg <= load_cnt_reg + IDX_W'(1);
            end
        end
    end

endmodule

// ===== design/dct_jobq.sv =====
// ---------------------------------------------------------------------------
// dct_jobq
// Two-entry job queue between the loader and the transform engine.
// ---------------------------------------------------------------------------
module dct_jobq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dct_pkg::job_t push_job,
    input  logic          pop,
    output dct_pkg::job_t pop_job,
    output logic          empty
);
    import dct_pkg::*;

    job_t       slot_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign empty   = (count_reg == 2'd0);
    assign do_push = push && (count_reg != 2'd2);
    assign do_pop  = pop && !empty;
    assign pop_job = slot_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (do_pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            count_reg <= count_reg + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

// ===== design/dct_back.sv =====
// ---------------------------------------------------------------------------
// dct_back
// Transform engine: two passes of multiply-accumulate on one shared multiplier.
// ---------------------------------------------------------------------------
module dct_back #(
    parameter int COEF_FRAC_BITS = dct_pkg::COEF_FRAC_BITS_DEF,
    parameter int SAMPLE_BITS    = dct_pkg::SAMPLE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        job_valid,
    input  dct_pkg::job_t               job,
    output logic                        job_pop,
    output logic                        in_re,
    output logic [dct_pkg::IDX_W-1:0]   in_raddr,
    input  logic [SAMPLE_BITS-1:0]      in_rdata,
    output dct_pkg::back_status_t       status,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [dct_pkg::DATA_W-1:0]  result_value,
    output logic                        last_of_block
);
    import dct_pkg::*;

    localparam int CW   = COEF_FRAC_BITS + 1;
    localparam int P1W  = SAMPLE_BITS + COEF_FRAC_BITS + 3;
    localparam int LO_W = (P1W + 1) / 2;
    localparam int HI_W = P1W - LO_W;
    localparam int MW   = (SAMPLE_BITS > LO_W + 1) ? SAMPLE_BITS : LO_W + 1;
    localparam int PW   = MW + CW;
    localparam int ACCW = P1W + CW + 3;
    localparam int SHF  = 2 * COEF_FRAC_BITS - 3;
    localparam int SHI  = 2 * COEF_FRAC_BITS;
    localparam logic [ACCW-1:0] RND_FWD = (ACCW'(1) << (SHF - 1)) - ACCW'(1);
    localparam logic [ACCW-1:0] RND_INV = ACCW'(1) << (SHI - 1);
    localparam logic signed [ACCW-1:0] LIM_HI = (ACCW'(1) << (SAMPLE_BITS - 1)) - ACCW'(1);
    localparam logic signed [ACCW-1:0] LIM_LO = ~LIM_HI;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PASS1,
        ST_DRAIN1,
        ST_PASS2,
        ST_DRAIN2
    } state_t;

    typedef struct packed {
        logic             valid;
        logic             pass2;
        logic             first;
        logic             last;
        logic             half;
        logic [IDX_W-1:0] idx;
    } tag_t;

    state_t           state_reg;
    logic [IDX_W-1:0] o_reg;
    logic [2:0]       k_reg;
    logic             h_reg;
    logic             mode_reg;
    tag_t             t1_reg;
    tag_t             t2_reg;
    tag_t             iss;
    logic             fin_valid_reg;
    logic             fin_last_reg;
    logic             out_valid_reg;
    logic             last_reg;
    logic signed [SAMPLE_BITS-1:0] result_reg;

    logic signed [CW-1:0]   cos_tab [COS_ENTRIES];
    logic signed [CW-1:0]   dc_coef;
    logic signed [CW-1:0]   coef_next;
    logic signed [CW-1:0]   coef_t1_reg;
    logic signed [MW-1:0]   op_a;
    logic signed [PW-1:0]   prod_next;
    logic signed [PW-1:0]   prod_reg;
    logic signed [ACCW-1:0] term;
    logic signed [ACCW-1:0] acc_next;
    logic signed [ACCW-1:0] acc_reg;
    logic signed [ACCW-1:0] fin_reg;
    logic signed [ACCW-1:0] sum_w;
    logic signed [ACCW-1:0] shr_w;
    logic signed [SAMPLE_BITS-1:0] sat_w;

    logic [2:0]       row;
    logic [2:0]       col;
    logic [6:0]       kp;
    logic [4:0]       kr;
    logic [3:0]       ki;
    logic             neg;
    logic [2:0]       a_i;
    logic [2:0]       b_i;
    logic             en;
    logic             issuing;
    logic             fp_we;
    logic             fp_re;
    logic [IDX_W-1:0] fp_raddr;
    logic [P1W-1:0]   fp_rdata;
    logic signed [HI_W-1:0] hi_part;

    for (genvar i = 0; i < COS_ENTRIES; i++)
    begin : g_cos
        assign cos_tab[i] = CW'(rom_round(COS_ROM[i], COEF_FRAC_BITS));
    end
    assign dc_coef = CW'(rom_round(DC_ROM, COEF_FRAC_BITS));

    assign en      = !out_valid_reg || out_ready;
    assign issuing = (state_reg == ST_PASS1) || (state_reg == ST_PASS2);
    assign a_i     = o_reg[5:3];
    assign b_i     = o_reg[2:0];
    assign job_pop = (state_reg == ST_IDLE) && job_valid;
    assign status.input_busy = (state_reg == ST_PASS1);

    // Address and coefficient for the term being issued
    always_comb
    begin
        if (state_reg == ST_PASS2)
        begin
            row      = mode_reg ? k_reg : b_i;
            col      = mode_reg ? a_i : k_reg;
            in_raddr = {a_i, k_reg};
            fp_raddr = mode_reg ? {k_reg, b_i} : {a_i, k_reg};
        end
        else
        begin
            row      = mode_reg ? k_reg : a_i;
            col      = mode_reg ? b_i : k_reg;
            in_raddr = mode_reg ? {a_i, k_reg} : {k_reg, b_i};
            fp_raddr = {a_i, k_reg};
        end
    end

    always_comb
    begin
        kp  = 7'(row) * (7'(col) * 7'd2 + 7'd1);
        kr  = kp[4:0];
        neg = 1'b0;
        if (kr > 5'd16)
        begin
            kr = 5'(6'd32 - 6'(kr));
        end
        if (kr > 5'd8)
        begin
            ki  = 4'(5'd16 - kr);
            neg = 1'b1;
        end
        else
        begin
            ki = kr[3:0];
        end
        if (row == 3'd0)
        begin
            coef_next = dc_coef;
        end
        else if (neg)
        begin
            coef_next = -cos_tab[ki];
        end
        else
        begin
            coef_next = cos_tab[ki];
        end
    end

    always_comb
    begin
        iss.valid = issuing;
        iss.pass2 = (state_reg == ST_PASS2);
        iss.half  = h_reg && (state_reg == ST_PASS2);
        iss.first = (k_reg == 3'd0) && !h_reg;
        iss.last  = (k_reg == 3'd7) && (h_reg || (state_reg == ST_PASS1));
        iss.idx   = o_reg;
    end

    assign in_re = en && (state_reg == ST_PASS1);
    assign fp_re = en && (state_reg == ST_PASS2);

    // Operand selection, multiply, accumulate
    assign hi_part = fp_rdata[P1W-1:LO_W];

    always_comb
    begin
        if (!t1_reg.pass2)
        begin
            op_a = MW'($signed(in_rdata));
        end
        else if (t1_reg.half)
        begin
            op_a = MW'(hi_part);
        end
        else
        begin
            op_a = $signed(MW'(fp_rdata[LO_W-1:0]));
        end
        prod_next = op_a * coef_t1_reg;
    end

    always_comb
    begin
        term = ACCW'(prod_reg);
        if (t2_reg.pass2 && t2_reg.half)
        begin
            term = term <<< LO_W;
        end
        acc_next = t2_reg.first ? term : acc_reg + term;
    end

    assign fp_we = en && t2_reg.valid && !t2_reg.pass2 && t2_reg.last;

    dct_ram #(
        .WIDTH (P1W),
        .DEPTH (BLK_ITEMS)
    ) u_fp_ram (
        .clk   (clk),
        .we    (fp_we),
        .waddr (t2_reg.idx),
        .wdata (P1W'(acc_next)),
        .re    (fp_re),
        .raddr (fp_raddr),
        .rdata (fp_rdata)
    );

    // Round, shift, saturate
    always_comb
    begin
        sum_w = fin_reg + $signed(mode_reg ? RND_INV : RND_FWD);
        shr_w = mode_reg ? (sum_w >>> SHI) : (sum_w >>> SHF);
        if (shr_w > LIM_HI)
        begin
            sat_w = SAMPLE_BITS'(LIM_HI);
        end
        else if (shr_w < LIM_LO)
        begin
            sat_w = SAMPLE_BITS'(LIM_LO);
        end
        else
        begin
            sat_w = SAMPLE_BITS'(shr_w);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            coef_t1_reg <= coef_next;
            prod_reg    <= prod_next;
            if (t2_reg.valid)
            begin
                acc_reg <= acc_next;
            end
            if (t2_reg.valid && t2_reg.pass2 && t2_reg.last)
            begin
                fin_reg <= acc_next;
            end
            if (fin_valid_reg)
            begin
                result_reg <= sat_w;
                last_reg   <= fin_last_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            o_reg         <= '0;
            k_reg         <= '0;
            h_reg         <= 1'b0;
            mode_reg      <= 1'b0;
            t1_reg        <= '0;
            t2_reg        <= '0;
            fin_valid_reg <= 1'b0;
            fin_last_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                t1_reg        <= iss;
                t2_reg        <= t1_reg;
                fin_valid_reg <= t2_reg.valid && t2_reg.pass2 && t2_reg.last;
                fin_last_reg  <= (t2_reg.idx == IDX_W'(BLK_ITEMS - 1));
                if (fin_valid_reg)
                begin
                    out_valid_reg <= 1'b1;
                end
                else if (out_ready)
                begin
                    out_valid_reg <= 1'b0;
                end
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (job_valid)
                    begin
                        mode_reg  <= job.inverse;
                        o_reg     <= '0;
                        k_reg     <= '0;
                        h_reg     <= 1'b0;
                        state_reg <= ST_PASS1;
                    end
                end
                ST_PASS1:
                begin
                    if (en)
                    begin
                        k_reg <= k_reg + 3'd1;
                        if (k_reg == 3'd7)
                        begin
                            o_reg <= o_reg + IDX_W'(1);
                            if (o_reg == IDX_W'(BLK_ITEMS - 1))
                            begin
                                state_reg <= ST_DRAIN1;
                            end
                        end
                    end
                end
                ST_DRAIN1:
                begin
                    if (!t1_reg.valid && !t2_reg.valid)
                    begin
                        o_reg     <= '0;
                        k_reg     <= '0;
                        h_reg     <= 1'b0;
                        state_reg <= ST_PASS2;
                    end
                end
                ST_PASS2:
                begin
                    if (en)
                    begin
                        h_reg <= ~h_reg;
                        if (h_reg)
                        begin
                            k_reg <= k_reg + 3'd1;
                            if (k_reg == 3'd7)
                            begin
                                o_reg <= o_reg + IDX_W'(1);
                                if (o_reg == IDX_W'(BLK_ITEMS - 1))
                                begin
                                    state_reg <= ST_DRAIN2;
                                end
                            end
                        end
                    end
                end
                ST_DRAIN2:
                begin
                    if (!t1_reg.valid && !t2_reg.valid && !fin_valid_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_value  = DATA_W'(result_reg);
    assign last_of_block = last_reg;

endmodule

// ===== design/dct_8x8_forward_inverse.sv =====
// A block of 64 samples is loaded in row-major order at one item per cycle
// while in_ready is high. After the 64th item the engine runs the first
// pass (64 outputs x 8 terms, one term per cycle unless the output stalls)
// with the input port held off, then the second pass, where each term is
// split into a low and a high half that take turns on the one shared
// multiplier. The next block may be loaded during the second pass. The
// block rate is therefore set by the single multiply-accumulate unit.
// ---------------------------------------------------------------------------
// dct_8x8_forward_inverse
// 8x8 orthonormal 2-D DCT-II, forward (scaled by 8) or inverse, by register.
// ---------------------------------------------------------------------------
module dct_8x8_forward_inverse #(
    parameter int COEF_FRAC_BITS = dct_pkg::COEF_FRAC_BITS_DEF,
    parameter int SAMPLE_BITS    = dct_pkg::SAMPLE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write_en,
    input  logic                        cfg_write_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [dct_pkg::DATA_W-1:0]  sample_value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [dct_pkg::DATA_W-1:0]  result_value,
    output logic                        last_of_block
);
    import dct_pkg::*;

    logic               in_we;
    logic [IDX_W-1:0]   in_waddr;
    logic [SAMPLE_BITS-1:0] in_wdata;
    logic               in_re;
    logic [IDX_W-1:0]   in_raddr;
    logic [SAMPLE_BITS-1:0] in_rdata;
    logic               push;
    job_t               push_job;
    logic               pop;
    job_t               pop_job;
    logic               q_empty;
    back_status_t       status;

    dct_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample_value   (sample_value),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .q_empty        (q_empty),
        .status         (status),
        .ram_we         (in_we),
        .ram_waddr      (in_waddr),
        .ram_wdata      (in_wdata),
        .push           (push),
        .push_job       (push_job)
    );

    dct_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (BLK_ITEMS)
    ) u_in_ram (
        .clk   (clk),
        .we    (in_we),
        .waddr (in_waddr),
        .wdata (in_wdata),
        .re    (in_re),
        .raddr (in_raddr),
        .rdata (in_rdata)
    );

    dct_jobq u_jobq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    dct_back #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_valid     (!q_empty),
        .job           (pop_job),
        .job_pop       (pop),
        .in_re         (in_re),
        .in_raddr      (in_raddr),
        .in_rdata      (in_rdata),
        .status        (status),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_value  (result_value),
        .last_of_block (last_of_block)
    );

endmodule

// ===== design/dct_checker.sv =====
// ---------------------------------------------------------------------------
// dct_checker
// Port-level checks on block framing and output hold.
// ---------------------------------------------------------------------------
module dct_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [dct_pkg::DATA_W-1:0]  result_value,
    input logic                        last_of_block
);
    import dct_pkg::*;

    logic [IDX_W-1:0] in_cnt_reg;
    logic [IDX_W-1:0] out_cnt_reg;
    logic [2:0]       pend_reg;
    logic             in_acc;
    logic             out_acc;
    logic             blk_in;
    logic             blk_out;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;
    assign blk_in  = in_acc && (in_cnt_reg == IDX_W'(BLK_ITEMS - 1));
    assign blk_out = out_acc && last_of_block;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_cnt_reg  <= '0;
            out_cnt_reg <= '0;
            pend_reg    <= '0;
        end
        else
        begin
            if (in_acc)
            begin
                in_cnt_reg <= in_cnt_reg + IDX_W'(1);
            end
            if (out_acc)
            begin
                out_cnt_reg <= out_cnt_reg + IDX_W'(1);
            end
            pend_reg <= pend_reg + 3'(blk_in) - 3'(blk_out);
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_value)
            && $stable(last_of_block))
        else $error("result item changed while stalled");

    a_last_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_of_block == (out_cnt_reg == IDX_W'(BLK_ITEMS - 1))))
        else $error("last flag not on the 64th result");

    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pend_reg != 3'd0))
        else $error("result item before a full block was loaded");

endmodule

bind dct_8x8_forward_inverse dct_checker u_dct_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_value  (result_value),
    .last_of_block (last_of_block)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Testbench of the 8x8 forward/inverse DCT. Three blocks of samples are
// pushed through the block in both modes with random gaps on both sides. A
// fixed-point model of the transform predicts every result, and a
// scoreboard checks each result and its last flag in order.
// ---------------------------------------------------------------------------
module tb_top;
    import dct_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 3000;
    localparam int TAIL_ITEMS     = 16;

    class dct_scoreboard;
        bit               inverse;
        longint           samples[BLK_ITEMS];
        int               fill;
        logic [DATA_W:0]  expected_q[$];
        int               failures;

        function longint coef_of(int row, int col);
            int     k;
            bit     neg;
            longint t;
            longint v;
            int     sh;
            neg = 0;
            sh  = ROM_FRAC_BITS - COEF_FRAC_BITS_DEF;
            if (row == 0)
            begin
                t = DC_ROM;
            end
            else
            begin
                k = (row * (2 * col + 1)) % 32;
                if (k > 16)
                    k = 32 - k;
                if (k > 8)
                begin
                    k   = 16 - k;
                    neg = 1;
                end
                t = COS_ROM[k];
            end
            v = (t + (longint'(1) << (sh - 1))) >>> sh;
            return neg ? -v : v;
        endfunction

        function logic [DATA_W-1:0] round_sat(logic signed [127:0] acc, int shift,
                                              bit half_up);
            logic signed [127:0] r;
            logic signed [127:0] one;
            one = 1;
            r   = acc + (one <<< (shift - 1)) - (half_up ? 0 : one);
            r   = r >>> shift;
            if (r > 32767)
                return 16'h7fff;
            if (r < -32768)
                return 16'h8000;
            return r[DATA_W-1:0];
        endfunction

        function void transform_block();
            longint              pass1[BLK_ITEMS];
            logic signed [127:0] acc;
            logic signed [127:0] cw;
            logic signed [127:0] pw;
            longint              s;
            logic [DATA_W-1:0]   res;
            for (int a = 0; a < 8; a++)
                for (int b = 0; b < 8; b++)
                begin
                    s = 0;
                    for (int k = 0; k < 8; k++)
                        s += inverse ? samples[a*8+k] * coef_of(k, b)
                                     : coef_of(a, k) * samples[k*8+b];
                    pass1[a*8+b] = s;
                end
            for (int a = 0; a < 8; a++)
                for (int b = 0; b < 8; b++)
                begin
                    acc = 0;
                    for (int k = 0; k < 8; k++)
                    begin
                        cw = inverse ? coef_of(k, a) : coef_of(b, k);
                        pw = inverse ? pass1[k*8+b] : pass1[a*8+k];
                        acc += cw * pw;
                    end
                    if (inverse)
                        res = round_sat(acc, 2 * COEF_FRAC_BITS_DEF, 1);
                    else
                        res = round_sat(acc, 2 * COEF_FRAC_BITS_DEF - 3, 0);
                    expected_q.push_back({(a == 7 && b == 7), res});
                end
        endfunction

        function void note_sample(logic [DATA_W-1:0] v);
            samples[fill] = longint'($signed(v));
            fill++;
            if (fill == BLK_ITEMS)
            begin
                fill = 0;
                transform_block();
            end
        endfunction

        function void check_result(logic [DATA_W-1:0] v, logic last);
            logic [DATA_W:0] e;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result value %h last %b", $time, v, last);
                failures++;
                return;
            end
            e = expected_q.pop_front();
            if (e[DATA_W-1:0] !== v)
            begin
                $display("%0t: result_value expected %h actual %h", $time,
                         e[DATA_W-1:0], v);
                failures++;
            end
            if (e[DATA_W] !== last)
            begin
                $display("%0t: last_of_block expected %b actual %b", $time,
                         e[DATA_W], last);
                failures++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_write_en;
    logic              cfg_write_data;
    logic              in_valid;
    logic              in_ready;
    logic [DATA_W-1:0] sample_value;
    logic              out_valid;
    logic              out_ready;
    logic [DATA_W-1:0] result_value;
    logic              last_of_block;

    dct_scoreboard sb;
    int            results_seen;
    int            idle_cycles;

    dct_8x8_forward_inverse dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample_value   (sample_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_value   (result_value),
        .last_of_block  (last_of_block)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_sample(sample_value);
            if (out_valid && out_ready)
            begin
                sb.check_result(result_value, last_of_block);
                results_seen++;
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("** dct_8x8_forward_inverse: FAILED **");
                $finish;
            end
        end
    end

    // receiver: random stalls, one long hold at the first result item
    initial
    begin
        int  gap;
        bit  held;
        held = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && out_valid && results_seen == 0)
            begin
                held = 1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            gap = pick_gap();
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    task automatic send_sample(logic [DATA_W-1:0] v, bit no_gaps);
        int gap;
        in_valid     <= 1'b1;
        sample_value <= v;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic set_mode(bit inverse);
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= inverse;
        @(negedge clk);
        cfg_write_en   <= 1'b0;
        sb.inverse = inverse;
    endtask

    function logic [DATA_W-1:0] random_sample(int style);
        case (style)
            0:       return DATA_W'($urandom_range(0, 65535));
            1:       return DATA_W'($signed($urandom_range(0, 127)) - 64);
            default: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        endcase
    endfunction

    initial
    begin
        sb             = new();
        results_seen   = 0;
        idle_cycles    = 0;
        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = 1'b0;
        in_valid       = 1'b0;
        sample_value   = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // forward, all maximum but for one minimum and one zero sample
        set_mode(1'b0);
        for (int i = 0; i < BLK_ITEMS; i++)
            send_sample(i == 9 ? 16'h8000 : (i == 20 ? 16'h0000 : 16'h7fff), 0);

        // forward, random block loaded while the first one is held at the output
        for (int i = 0; i < BLK_ITEMS; i++)
            send_sample(random_sample(0), 0);

        // keep offering items while both blocks are in the engine
        for (int i = 0; i < TAIL_ITEMS; i++)
            send_sample(random_sample(1 + (i & 1)), 1);

        // inverse, finish the block with a checkerboard of extremes
        set_mode(1'b1);
        for (int i = TAIL_ITEMS; i < BLK_ITEMS; i++)
            send_sample((((i >> 3) ^ i) & 1) ? 16'h8000 : 16'h7fff, 1);

        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
        if (sb.failures == 0)
            $display("** dct_8x8_forward_inverse: PASSED **");
        else
            $display("** dct_8x8_forward_inverse: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
design/dct_pkg.sv
design/dct_ram.sv
design/dct_front.sv
design/dct_jobq.sv
design/dct_back.sv
design/dct_8x8_forward_inverse.sv
design/dct_checker.sv
tb/tb_top.sv
